>>> rtl/core/bdm_pkg.sv
// shared types and constants of the block delay map lookup
`default_nettype none

package bdm_pkg;

    localparam int COORD_W    = 10;               // block column and row
    localparam int FIELD_W    = 7;                // slot and delay ports
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int SQRT_STEPS = 11;               // bit pairs of the squared radius
    localparam int SQ_W       = 2 * SQRT_STEPS;   // radicand and root working width
    localparam int ROOT_W     = SQRT_STEPS;

    localparam logic [MODE_W-1:0] MODE_VSTRIPE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HSTRIPE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RINGS   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [MODE_W-1:0]  MODE_RESET   = MODE_RINGS;
    localparam logic [COORD_W-1:0] WIDTH_RESET  = 10'd320;
    localparam logic [COORD_W-1:0] HEIGHT_RESET = 10'd240;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [COORD_W-1:0] map_width;
        logic [COORD_W-1:0] map_height;
    } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/bdm_front.sv
// front stages: clamp and mirror, offsets from the centre, squares and their sum
`default_nettype none

module bdm_front
    import bdm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 71
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_vld,
    input  wire logic [COORD_W-1:0]                block_col,
    input  wire logic [COORD_W-1:0]                block_row,
    input  wire logic [FIELD_W-1:0]                newest_slot,
    input  wire cfg_t                              cfg,
    output logic                                   out_vld,
    output logic [SQ_W-1:0]                        sq_sum,
    output logic [COORD_W-1:0]                     lin,
    output logic                                   root_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0]         nmod
);

    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int NM_W   = FIELD_W + 9;
    localparam int PROD_W = 2 * COORD_W;

    // stage 1: clamped position mirrored into map coordinates
    logic                  v1_reg;
    logic [COORD_W-1:0]    x_reg, x_next;
    logic [COORD_W-1:0]    y_reg, y_next;
    logic [SLOT_W-1:0]     nm1_reg, nm1_next;
    // stage 2: distances from the centre
    logic                  v2_reg;
    logic [COORD_W-1:0]    dx_reg, dx_next;
    logic [COORD_W-1:0]    dy_reg, dy_next;
    logic [COORD_W-1:0]    lin2_reg, lin2_next;
    logic                  ren2_reg, ren2_next;
    logic [SLOT_W-1:0]     nm2_reg;
    // stage 3: squares
    logic                  v3_reg;
    logic [PROD_W-1:0]     sqx_reg, sqx_next;
    logic [PROD_W-1:0]     sqy_reg, sqy_next;
    logic [COORD_W-1:0]    lin3_reg;
    logic                  ren3_reg;
    logic [SLOT_W-1:0]     nm3_reg;
    // stage 4: squared radius
    logic                  v4_reg;
    logic [SQ_W-1:0]       sum_reg, sum_next;
    logic [COORD_W-1:0]    lin4_reg;
    logic                  ren4_reg;
    logic [SLOT_W-1:0]     nm4_reg;

    logic [COORD_W-1:0]    col_c;
    logic [COORD_W-1:0]    row_c;
    logic [COORD_W-1:0]    cx;
    logic [COORD_W-1:0]    cy;
    logic [NM_W-1:0]       rem;

    always_comb
    begin
        col_c = block_col;
        if (block_col >= cfg.map_width)
        begin
            col_c = (cfg.map_width != '0) ? cfg.map_width - 10'd1 : '0;
        end
        row_c = block_row;
        if (block_row >= cfg.map_height)
        begin
            row_c = (cfg.map_height != '0) ? cfg.map_height - 10'd1 : '0;
        end
        x_next = cfg.map_width - col_c;
        y_next = cfg.map_height - row_c;

        // newest slot reduced by restoring subtraction of shifted depths
        rem = NM_W'(newest_slot);
        for (int k = FIELD_W - 1; k >= 0; k--)
        begin
            if (rem >= (NM_W'(QUEUE_DEPTH) << k))
            begin
                rem = rem - (NM_W'(QUEUE_DEPTH) << k);
            end
        end
        nm1_next = SLOT_W'(rem);
    end

    always_comb
    begin
        cx = cfg.map_width >> 1;
        cy = cfg.map_height >> 1;
        dx_next = (x_reg >= cx) ? x_reg - cx : cx - x_reg;
        dy_next = (y_reg >= cy) ? y_reg - cy : cy - y_reg;
        case (cfg.mode)
            MODE_VSTRIPE: lin2_next = dx_next;
            MODE_HSTRIPE: lin2_next = dy_next;
            default:      lin2_next = '0;
        endcase
        ren2_next = (cfg.mode == MODE_RINGS);
    end

    always_comb
    begin
        sqx_next = dx_reg * dx_reg;
        sqy_next = dy_reg * dy_reg;
        sum_next = SQ_W'(sqx_reg) + SQ_W'(sqy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        nm1_reg  <= nm1_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        lin2_reg <= lin2_next;
        ren2_reg <= ren2_next;
        nm2_reg  <= nm1_reg;
        sqx_reg  <= sqx_next;
        sqy_reg  <= sqy_next;
        lin3_reg <= lin2_reg;
        ren3_reg <= ren2_reg;
        nm3_reg  <= nm2_reg;
        sum_reg  <= sum_next;
        lin4_reg <= lin3_reg;
        ren4_reg <= ren3_reg;
        nm4_reg  <= nm3_reg;
    end

    assign out_vld = v4_reg;
    assign sq_sum  = sum_reg;
    assign lin     = lin4_reg;
    assign root_en = ren4_reg;
    assign nmod    = nm4_reg;

endmodule

`default_nettype wire

>>> rtl/core/bdm_sqrt_cell.sv
// one bit-pair step of the integer square root, registered
`default_nettype none

module bdm_sqrt_cell
    import bdm_pkg::*;
#(
    parameter int STEP   = 0,
    parameter int SIDE_W = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_vld,
    input  wire logic [SQ_W-1:0]   in_rem,
    input  wire logic [SQ_W-1:0]   in_root,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_vld,
    output logic [SQ_W-1:0]        out_rem,
    output logic [SQ_W-1:0]        out_root,
    output logic [SIDE_W-1:0]      out_side
);

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * STEP);

    logic                vld_reg;
    logic [SQ_W-1:0]     rem_reg, rem_next;
    logic [SQ_W-1:0]     root_reg, root_next;
    logic [SIDE_W-1:0]   side_reg;
    logic [SQ_W-1:0]     trial;

    always_comb
    begin
        trial     = in_root | BIT;
        rem_next  = in_rem;
        root_next = in_root >> 1;
        if (in_rem >= trial)
        begin
            rem_next  = in_rem - trial;
            root_next = (in_root >> 1) | BIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        side_reg <= in_side;
    end

    assign out_vld  = vld_reg;
    assign out_rem  = rem_reg;
    assign out_root = root_reg;
    assign out_side = side_reg;

endmodule

`default_nettype wire

>>> rtl/core/bdm_tail.sv
// last stage: halve, saturate and wrap the source slot around the queue
`default_nettype none

module bdm_tail
    import bdm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 71
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_vld,
    input  wire logic [ROOT_W-1:0]             root,
    input  wire logic [COORD_W-1:0]            lin,
    input  wire logic                          root_en,
    input  wire logic [$clog2(QUEUE_DEPTH)-1:0] nmod,
    output logic                               done,
    output logic [FIELD_W-1:0]                 delay,
    output logic [FIELD_W-1:0]                 source_slot
);

    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int SUM_W  = SLOT_W + 1;
    localparam logic [ROOT_W-2:0] MAX_DLY = (ROOT_W - 1)'(QUEUE_DEPTH - 1);

    logic                done_reg;
    logic [SLOT_W-1:0]   dly_reg, dly_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [ROOT_W-1:0]   v;
    logic [ROOT_W-2:0]   half;
    logic [SUM_W-1:0]    sum;

    always_comb
    begin
        v    = root_en ? root : ROOT_W'(lin);
        half = v[ROOT_W-1:1];
        dly_next = (half > MAX_DLY) ? SLOT_W'(MAX_DLY) : SLOT_W'(half);
        // both terms are below the depth, so one subtract wraps it
        sum = SUM_W'(nmod) + SUM_W'(dly_next);
        if (sum >= SUM_W'(QUEUE_DEPTH))
        begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        slot_next = SLOT_W'(sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        dly_reg  <= dly_next;
        slot_reg <= slot_next;
    end

    assign done        = done_reg;
    assign delay       = FIELD_W'(dly_reg);
    assign source_slot = FIELD_W'(slot_reg);

    a_dly_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (dly_reg <= SLOT_W'(QUEUE_DEPTH - 1)))
        else $error("delay beyond the last queue slot");

    a_slot_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (SUM_W'(slot_reg) < SUM_W'(QUEUE_DEPTH)))
        else $error("source slot outside the queue");

    a_nmod_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld |=> (SUM_W'($past(nmod)) < SUM_W'(QUEUE_DEPTH)))
        else $error("reduced newest slot outside the queue");

endmodule

`default_nettype wire

>>> rtl/core/block_delay_map_lookup.sv
// block delay map lookup: per-block frame delay and queue slot, pipelined
//
// Usage: raise start with block_col, block_row and newest_slot for one
// cycle; the word is taken at that edge whenever busy is low, and busy
// never rises, so a new word may be offered in every cycle. When the answer
// comes back, done is high for exactly one cycle with delay and
// source_slot valid beside it. The receiver cannot hold results off, so
// nothing ever waits inside the block.
// The pipeline has four front stages (clamp and mirror, distance from the
// centre, squares, sum), eleven square root cells, one per bit pair of
// the 22-bit squared radius, and one output stage.
// Throughput is one word per cycle in every mode.
// Configuration: cfg_wr with cfg_addr and cfg_wdata writes mode (0),
// map_width (1) or map_height (2) at the clock edge; write only while no
// lookup is in flight. Index 3 is ignored.
// Reset empties the pipeline and sets mode 4 (rings) on a 320 by 240 grid.

`default_nettype none

module block_delay_map_lookup
    import bdm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 71
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [COORD_W-1:0]   block_col,
    input  wire logic [COORD_W-1:0]   block_row,
    input  wire logic [FIELD_W-1:0]   newest_slot,
    output logic                      done,
    output logic [FIELD_W-1:0]        delay,
    output logic [FIELD_W-1:0]        source_slot,
    input  wire logic                 cfg_wr,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [COORD_W-1:0]   cfg_wdata
);

    localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
    localparam int SIDE_W  = COORD_W + 1 + SLOT_W;
    localparam int LATENCY = 4 + SQRT_STEPS + 1;

    cfg_t                cfg_reg, cfg_next;
    logic                accept;

    logic                f_vld;
    logic [SQ_W-1:0]     f_sum;
    logic [COORD_W-1:0]  f_lin;
    logic                f_ren;
    logic [SLOT_W-1:0]   f_nmod;

    logic                c_vld  [0:SQRT_STEPS];
    logic [SQ_W-1:0]     c_rem  [0:SQRT_STEPS];
    logic [SQ_W-1:0]     c_root [0:SQRT_STEPS];
    logic [SIDE_W-1:0]   c_side [0:SQRT_STEPS];

    logic [COORD_W-1:0]  t_lin;
    logic                t_ren;
    logic [SLOT_W-1:0]   t_nmod;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (cfg_addr)
                CFG_MODE:   cfg_next.mode       = cfg_wdata[MODE_W-1:0];
                CFG_WIDTH:  cfg_next.map_width  = cfg_wdata;
                CFG_HEIGHT: cfg_next.map_height = cfg_wdata;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode       <= MODE_RESET;
            cfg_reg.map_width  <= WIDTH_RESET;
            cfg_reg.map_height <= HEIGHT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bdm_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_vld      (accept),
        .block_col   (block_col),
        .block_row   (block_row),
        .newest_slot (newest_slot),
        .cfg         (cfg_reg),
        .out_vld     (f_vld),
        .sq_sum      (f_sum),
        .lin         (f_lin),
        .root_en     (f_ren),
        .nmod        (f_nmod)
    );

    assign c_vld[0]  = f_vld;
    assign c_rem[0]  = f_sum;
    assign c_root[0] = '0;
    assign c_side[0] = {f_lin, f_ren, f_nmod};

    // cell i tries bit pair SQRT_STEPS-1-i, most significant first
    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_cell
        bdm_sqrt_cell #(
            .STEP   (SQRT_STEPS - 1 - i),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (c_vld[i]),
            .in_rem   (c_rem[i]),
            .in_root  (c_root[i]),
            .in_side  (c_side[i]),
            .out_vld  (c_vld[i+1]),
            .out_rem  (c_rem[i+1]),
            .out_root (c_root[i+1]),
            .out_side (c_side[i+1])
        );
    end

    assign {t_lin, t_ren, t_nmod} = c_side[SQRT_STEPS];

    bdm_tail #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_tail (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_vld      (c_vld[SQRT_STEPS]),
        .root        (c_root[SQRT_STEPS][ROOT_W-1:0]),
        .lin         (t_lin),
        .root_en     (t_ren),
        .nmod        (t_nmod),
        .done        (done),
        .delay       (delay),
        .source_slot (source_slot)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted word produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without an accepted word");

    a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_wr |=> $stable(cfg_reg))
        else $error("configuration changed without a write");

endmodule

`default_nettype wire

>>> bench/bdm_lookup_checker.sv
// checker for the block delay map lookup: predicts every accepted word and compares results
module bdm_lookup_checker
    import bdm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 71
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire logic [COORD_W-1:0]   block_col,
    input  wire logic [COORD_W-1:0]   block_row,
    input  wire logic [FIELD_W-1:0]   newest_slot,
    input  wire logic                 done,
    input  wire logic [FIELD_W-1:0]   delay,
    input  wire logic [FIELD_W-1:0]   source_slot,
    input  wire logic                 cfg_wr,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [COORD_W-1:0]   cfg_wdata,
    output int                        mismatch_count,
    output int                        words_in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [FIELD_W-1:0] newest;
        logic [FIELD_W-1:0] delay;
        logic [FIELD_W-1:0] source_slot;
    } lookup_t;

    cfg_t    map_cfg;
    lookup_t pending_lookups[$];

    initial mismatch_count = 0;

    function automatic int unsigned floor_root(int unsigned radicand);
        int unsigned root;
        int unsigned trial;
        root = 0;
        for (int b = 15; b >= 0; b--)
        begin
            trial = root | (32'd1 << b);
            if (trial * trial <= radicand)
                root = trial;
        end
        return root;
    endfunction

    function automatic lookup_t predict_lookup(cfg_t c, logic [COORD_W-1:0] col,
                                               logic [COORD_W-1:0] row,
                                               logic [FIELD_W-1:0] newest);
        lookup_t     p;
        int unsigned w, h, cc, rr, x, y, dx, dy, span, d;
        w  = c.map_width;
        h  = c.map_height;
        cc = col;
        rr = row;
        // positions off the grid stick to the last column or row
        if (cc >= w)
            cc = (w != 0) ? w - 1 : 0;
        if (rr >= h)
            rr = (h != 0) ? h - 1 : 0;
        // map is stored mirrored, counted from 1
        x  = w - cc;
        y  = h - rr;
        dx = (x >= w / 2) ? x - w / 2 : w / 2 - x;
        dy = (y >= h / 2) ? y - h / 2 : h / 2 - y;
        case (c.mode)
            MODE_VSTRIPE: span = dx;
            MODE_HSTRIPE: span = dy;
            MODE_RINGS:   span = floor_root(dx * dx + dy * dy);
            default:      span = 0;
        endcase
        d = span / 2;
        if (d > QUEUE_DEPTH - 1)
            d = QUEUE_DEPTH - 1;
        p.col         = col;
        p.row         = row;
        p.newest      = newest;
        p.delay       = d[FIELD_W-1:0];
        p.source_slot = FIELD_W'((newest + d) % QUEUE_DEPTH);
        return p;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        lookup_t want;
        if (!rst_n)
        begin
            map_cfg <= '{MODE_RESET, WIDTH_RESET, HEIGHT_RESET};
            pending_lookups.delete();
            words_in_flight <= 0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_addr)
                    CFG_MODE:   map_cfg.mode       <= cfg_wdata[MODE_W-1:0];
                    CFG_WIDTH:  map_cfg.map_width  <= cfg_wdata;
                    CFG_HEIGHT: map_cfg.map_height <= cfg_wdata;
                    default:    ;
                endcase
            end
            if (start && !busy)
                pending_lookups.push_back(predict_lookup(map_cfg, block_col, block_row,
                                                         newest_slot));
            if (done)
            begin
                if (pending_lookups.size() == 0)
                begin
                    report_mismatch($sformatf("result with no word pending: delay %0d slot %0d",
                                              delay, source_slot));
                end
                else
                begin
                    want = pending_lookups.pop_front();
                    if (delay !== want.delay)
                        report_mismatch($sformatf(
                            "delay got %0d want %0d (col %0d row %0d newest %0d)",
                            delay, want.delay, want.col, want.row, want.newest));
                    if (source_slot !== want.source_slot)
                        report_mismatch($sformatf(
                            "source_slot got %0d want %0d (col %0d row %0d newest %0d)",
                            source_slot, want.source_slot, want.col, want.row, want.newest));
                end
            end
            words_in_flight <= pending_lookups.size();
        end
    end

endmodule

>>> bench/tb_block_delay_map_lookup.sv
// top of the block delay map lookup testbench: clock, reset, stimulus and verdict
module tb_block_delay_map_lookup;
    timeunit 1ns;
    timeprecision 1ps;

    import bdm_pkg::*;

    localparam int QUEUE_DEPTH = 71;
    localparam logic [MODE_W-1:0]    MODE_UNUSED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 start       = 1'b0;
    logic [COORD_W-1:0]   block_col   = '0;
    logic [COORD_W-1:0]   block_row   = '0;
    logic [FIELD_W-1:0]   newest_slot = '0;
    logic                 cfg_wr      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr    = '0;
    logic [COORD_W-1:0]   cfg_wdata   = '0;
    logic                 busy;
    logic                 done;
    logic [FIELD_W-1:0]   delay;
    logic [FIELD_W-1:0]   source_slot;
    int                   mismatch_count;
    int                   words_in_flight;

    int unsigned cur_width  = WIDTH_RESET;
    int unsigned cur_height = HEIGHT_RESET;

    block_delay_map_lookup #(.QUEUE_DEPTH(QUEUE_DEPTH)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .block_col(block_col), .block_row(block_row), .newest_slot(newest_slot),
        .done(done), .delay(delay), .source_slot(source_slot),
        .cfg_wr(cfg_wr), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    bdm_lookup_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) lookup_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .block_col(block_col), .block_row(block_row), .newest_slot(newest_slot),
        .done(done), .delay(delay), .source_slot(source_slot),
        .cfg_wr(cfg_wr), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .mismatch_count(mismatch_count), .words_in_flight(words_in_flight)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // offer one word, optionally after an idle burst, and hold it until taken
    task automatic send_word(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                             input logic [FIELD_W-1:0] newest, input int idle_pct);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        start       <= 1'b1;
        block_col   <= col;
        block_row   <= row;
        newest_slot <= newest;
        do @(posedge clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (words_in_flight != 0);
    endtask

    task automatic set_config(input logic [MODE_W-1:0] m, input logic [COORD_W-1:0] w,
                              input logic [COORD_W-1:0] h);
        logic [COORD_W-1:0] mode_word;
        drain();
        // junk above the mode bits must be dropped
        mode_word = COORD_W'($urandom_range(0, 1023));
        mode_word[MODE_W-1:0] = m;
        cfg_wr    <= 1'b1;
        cfg_addr  <= CFG_MODE;
        cfg_wdata <= mode_word;
        @(posedge clk);
        cfg_addr  <= CFG_SPARE;
        cfg_wdata <= COORD_W'($urandom_range(0, 1023));
        @(posedge clk);
        cfg_addr  <= CFG_WIDTH;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_addr  <= CFG_HEIGHT;
        cfg_wdata <= h;
        @(posedge clk);
        cfg_wr     <= 1'b0;
        cur_width  = w;
        cur_height = h;
    endtask

    function automatic logic [COORD_W-1:0] pick_coord(int unsigned lim);
        int unsigned v;
        case ($urandom_range(0, 9))
            0:       v = 0;
            1:       v = (lim != 0) ? lim - 1 : 0;
            2:       v = lim;
            3:       v = 1023;
            4:       v = $urandom_range(0, 1023);
            default: v = (lim != 0) ? $urandom_range(0, lim - 1) : 0;
        endcase
        return v[COORD_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return COORD_W'(0);
            1:       return COORD_W'(1);
            2:       return COORD_W'(1023);
            3, 4:    return COORD_W'($urandom_range(2, 1023));
            default: return COORD_W'($urandom_range(2, 64));
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode();
        if ($urandom_range(0, 4) == 0)
            return MODE_W'($urandom_range(0, 7));
        return MODE_W'($urandom_range(MODE_VSTRIPE, MODE_RINGS));
    endfunction

    function automatic logic [FIELD_W-1:0] pick_slot();
        if ($urandom_range(0, 4) == 0)
            return FIELD_W'($urandom_range(0, 127));
        return FIELD_W'($urandom_range(0, QUEUE_DEPTH - 1));
    endfunction

    task automatic run_phase(input int n, input int idle_pct);
        for (int i = 0; i < n; i++)
            send_word(pick_coord(cur_width), pick_coord(cur_height), pick_slot(), idle_pct);
    endtask

    initial
    begin
        int idle_pct;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rings on the reset grid: origin, clamp, centre, corners, slots past the queue
        send_word(10'd0, 10'd0, 7'd0, 0);
        send_word(10'd1023, 10'd1023, 7'd127, 0);
        send_word(10'd160, 10'd120, 7'd70, 0);
        send_word(10'd319, 10'd0, 7'd1, 0);
        send_word(10'd0, 10'd239, 7'd71, 0);

        set_config(MODE_VSTRIPE, 10'd320, 10'd240);
        send_word(10'd0, 10'd5, 7'd70, 0);
        send_word(10'd160, 10'd7, 7'd3, 0);
        send_word(10'd1023, 10'd0, 7'd64, 0);

        set_config(MODE_HSTRIPE, 10'd320, 10'd240);
        send_word(10'd5, 10'd0, 7'd70, 0);
        send_word(10'd5, 10'd120, 7'd0, 0);
        send_word(10'd0, 10'd1023, 7'd42, 0);

        set_config(MODE_UNUSED, 10'd320, 10'd240);
        send_word(10'd0, 10'd0, 7'd70, 0);
        send_word(10'd1023, 10'd1023, 7'd127, 0);

        // empty grid
        set_config(MODE_RINGS, 10'd0, 10'd0);
        send_word(10'd0, 10'd0, 7'd5, 0);
        send_word(10'd1023, 10'd1023, 7'd70, 0);

        set_config(MODE_RINGS, 10'd1023, 10'd1023);
        send_word(10'd0, 10'd0, 7'd0, 0);
        send_word(10'd1022, 10'd1022, 7'd69, 0);
        send_word(10'd511, 10'd511, 7'd10, 0);
        send_word(10'd1023, 10'd0, 7'd127, 0);

        set_config(MODE_VSTRIPE, 10'd1, 10'd1);
        send_word(10'd0, 10'd0, 7'd70, 0);
        send_word(10'd1023, 10'd1023, 7'd7, 0);

        set_config(MODE_HSTRIPE, 10'd2, 10'd1023);
        send_word(10'd1, 10'd0, 7'd70, 0);

        for (int p = 0; p < 15; p++)
        begin
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 12;
                default: idle_pct = 50;
            endcase
            // the closing phases run back to back
            if (p >= 12)
                idle_pct = 0;
            set_config(pick_mode(), pick_dim(), pick_dim());
            run_phase(60, idle_pct);
        end

        drain();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && words_in_flight == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
